### hw/rtl/srq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_pkg
// Types, constants and the service-order compare for the sorted ready queue.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int unsigned SrqDepth = 32;

  typedef enum logic {
    KIND_INSERT  = 1'b0,
    KIND_EXTRACT = 1'b1
  } srq_kind_e;

  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] tleft;
    logic [15:0] pid;
  } srq_entry_t;

  typedef struct packed {
    srq_kind_e   kind;
    logic [7:0]  priority_req;
    logic [15:0] time_left;
    logic [15:0] proc_id;
  } srq_in_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  out_priority;
    logic [15:0] out_time_left;
    logic [15:0] out_proc_id;
    logic [5:0]  occupancy;
  } srq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic ext;
  } srq_ctrl_t;

  // true if a must be served before b
  function automatic logic srq_beats(srq_entry_t a, srq_entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = (a.prio > b.prio);
    end else if (a.tleft != b.tleft) begin
      res = (a.tleft < b.tleft);
    end else begin
      res = (a.pid < b.pid);
    end
    return res;
  endfunction

endpackage

### hw/rtl/srq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_cell
// One slot of the sorted chain: holds an entry, flags whether a new entry
// goes ahead of it, and shifts toward the tail on insert or the head on
// extract.
// ----------------------------------------------------------------------------
module srq_cell import srq_pkg::*; (
  input  logic       clk_i,
  input  srq_ctrl_t  ctrl_i,
  input  srq_entry_t new_entry_i,
  input  logic       occ_i,
  input  logic       beat_left_i,
  input  srq_entry_t left_entry_i,
  input  srq_entry_t right_entry_i,
  output logic       beat_o,
  output srq_entry_t entry_o
);

  srq_entry_t entry_q, entry_d;

  // an empty slot always yields to the new entry
  assign beat_o  = !occ_i || srq_beats(new_entry_i, entry_q);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (beat_o && !beat_left_i) begin
        entry_d = new_entry_i;
      end else if (beat_o) begin
        entry_d = left_entry_i;
      end
    end else if (ctrl_i.ext) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

### hw/rtl/srq_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srq_out_buf
// Output register plus skid stage, so a new beat can be taken while the
// previous result still waits downstream.
// ----------------------------------------------------------------------------
module srq_out_buf import srq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  srq_out_t res_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output srq_out_t out_data_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  srq_out_t out_q, out_d;
  srq_out_t skid_q, skid_d;
  logic     out_fire;

  assign out_fire    = out_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (load_i) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

### hw/rtl/sorted_ready_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_ready_queue_core
// Bounded ready queue kept in service order by a chain of compare-and-shift
// cells; insert in sorted place, extract from the head.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (srq_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (srq_out_t)
//
//  One beat per cycle unless the output buffer is full: every cell compares
//  against the new entry in parallel and the whole chain shifts in the same
//  cycle the beat is taken. The result lands in the output or skid register.
//  A two-deep output buffer stalls input only when both slots are held.
//  Reset clears the entry count and buffer flags; cell contents are not reset.
// ----------------------------------------------------------------------------
module sorted_ready_queue_core import srq_pkg::*; #(
  parameter int unsigned DEPTH = SrqDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  srq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output srq_out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            in_fire, ins_ok, ext_ok, buf_full;
  srq_ctrl_t       ctrl;
  srq_entry_t      new_entry;
  srq_entry_t      cell_entry [DEPTH];
  logic [DEPTH-1:0] beat, occ;
  srq_out_t        res;

  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;
  assign ins_ok     = in_fire && (in_data_i.kind == KIND_INSERT) &&
                      (count_q != CntW'(DEPTH));
  assign ext_ok     = in_fire && (in_data_i.kind == KIND_EXTRACT) &&
                      (count_q != '0);
  assign ctrl.ins   = ins_ok;
  assign ctrl.ext   = ext_ok;

  assign new_entry.prio  = in_data_i.priority_req;
  assign new_entry.tleft = in_data_i.time_left;
  assign new_entry.pid   = in_data_i.proc_id;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    srq_entry_t left_e, right_e;
    logic       beat_l;
    assign occ[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign beat_l = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign beat_l = beat[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_nxt
      assign right_e = cell_entry[i+1];
    end
    srq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .occ_i         (occ[i]),
      .beat_left_i   (beat_l),
      .left_entry_i  (left_e),
      .right_entry_i (right_e),
      .beat_o        (beat[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (ext_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_comb begin
    res.accepted      = ins_ok || ext_ok;
    res.out_priority  = ext_ok ? cell_entry[0].prio  : 8'd0;
    res.out_time_left = ext_ok ? cell_entry[0].tleft : 16'd0;
    res.out_proc_id   = ext_ok ? cell_entry[0].pid   : 16'd0;
    res.occupancy     = 6'(count_d);
  end

  srq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
